@@ sv/odpnd_pkg.sv @@
// ----------------------------------------------------------------------------
// OMA-DM push notification detector package
// Payload types and the fixed layout constants of the notification.
// ----------------------------------------------------------------------------
`default_nettype none

package odpnd_pkg;

   typedef logic [7:0] byte_type;

   localparam int unsigned PUSH_DEST_PORT = 2948;
   localparam int unsigned WDP_HEADER_LEN = 7;
   localparam int unsigned ID_LEN_OFFSET  = 29;
   localparam int unsigned NOTIF_VERSION  = 11;

   // WSP push header bytes expected at WSP offsets 1 to 5.
   localparam byte_type PUSH_HDR [5] = '{8'h06, 8'h03, 8'hc4, 8'haf, 8'h87};

   localparam byte_type WDP_PORT_HI    = byte_type'((PUSH_DEST_PORT >> 8) & 8'hff);
   localparam byte_type WDP_PORT_LO    = byte_type'(PUSH_DEST_PORT & 8'hff);
   localparam byte_type VERSION_HI     = byte_type'(NOTIF_VERSION >> 2);
   localparam logic [1:0] VERSION_LO   = 2'(NOTIF_VERSION & 3);
   localparam logic [3:0] FLAG_NIBBLE  = 4'h8;
   localparam byte_type PRINTABLE_MIN  = 8'h21;
   localparam byte_type PRINTABLE_MAX  = 8'h7e;

endpackage

`default_nettype wire

@@ sv/odpnd_req_if.sv @@
// ----------------------------------------------------------------------------
// Request channel of the notification detector
// One payload byte of a message and its last flag, with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface odpnd_req_if;
   logic                valid;
   logic                ready;
   odpnd_pkg::byte_type data_byte;
   logic                last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

@@ sv/odpnd_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Response channel of the notification detector
// One verdict per message, with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface odpnd_rsp_if;
   logic valid;
   logic ready;
   logic is_notification;

   modport source (output valid, output is_notification, input ready);
   modport sink   (input valid, input is_notification, output ready);
endinterface

`default_nettype wire

@@ sv/oma_dm_push_notification_detector.sv @@
// A request byte is registered in the check stage and checked there; the
// verdict on a last byte goes to the response register. Throughput: one byte
// per cycle while the response side takes verdicts; the check stage and a
// single response register set the pace. Reset clears the valid flags, the
// byte position, the mismatch flag, the identifier length and the WDP mode bit.
// ----------------------------------------------------------------------------
// OMA-DM push notification detector
// Checks a short message payload byte by byte against the layout of a
// server-initiated notification and gives a verdict on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module oma_dm_push_notification_detector #(
   parameter int unsigned POSITION_BITS = 9
) (
   input  wire                 clock,
   input  wire                 reset,
   odpnd_req_if.sink           req_if,
   odpnd_rsp_if.source         rsp_if,
   input  wire                 csr_write_enable,
   input  wire                 csr_write_data
);

   typedef logic [POSITION_BITS-1:0] pos_type;

   localparam pos_type POS_MAX  = '1;
   localparam pos_type WDP_BASE = POSITION_BITS'(odpnd_pkg::WDP_HEADER_LEN);
   localparam pos_type ID_OFF   = POSITION_BITS'(odpnd_pkg::ID_LEN_OFFSET);
   localparam pos_type ID_FIRST = POSITION_BITS'(odpnd_pkg::ID_LEN_OFFSET + 1);

   logic                wdp_mode_ff;
   logic                s1_valid_ff;
   odpnd_pkg::byte_type s1_byte_ff;
   logic                s1_last_ff;
   pos_type             pos_ff;
   pos_type             pos_in;
   logic                mismatch_ff;
   logic                mismatch_in;
   odpnd_pkg::byte_type sid_len_ff;
   odpnd_pkg::byte_type sid_len_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                verdict_ff;
   logic                verdict_in;

   logic                advance;
   logic                consume;
   pos_type             base;
   pos_type             wsp_pos;
   logic                in_wdp;
   logic                wdp_ok;
   logic                wsp_ok;
   logic                byte_ok;
   odpnd_pkg::byte_type b;

   assign advance       = !rsp_valid_ff || rsp_if.ready;
   assign consume       = s1_valid_ff && advance;
   assign req_if.ready  = !s1_valid_ff || advance;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.is_notification = verdict_ff;

   assign b       = s1_byte_ff;
   assign base    = wdp_mode_ff ? WDP_BASE : '0;
   assign in_wdp  = pos_ff < base;
   assign wsp_pos = pos_ff - base;

   always_comb begin
      wdp_ok = 1'b1;
      if (pos_ff == POSITION_BITS'(0) || pos_ff == POSITION_BITS'(2)) begin
         wdp_ok = (b == 8'h00);
      end else if (pos_ff == POSITION_BITS'(1)) begin
         wdp_ok = (b == 8'h01);
      end else if (pos_ff == POSITION_BITS'(5)) begin
         wdp_ok = (b == odpnd_pkg::WDP_PORT_HI);
      end else if (pos_ff == POSITION_BITS'(6)) begin
         wdp_ok = (b == odpnd_pkg::WDP_PORT_LO);
      end
   end

   always_comb begin
      wsp_ok = 1'b1;
      if (wsp_pos >= POSITION_BITS'(1) && wsp_pos <= POSITION_BITS'(5)) begin
         wsp_ok = (b == odpnd_pkg::PUSH_HDR[wsp_pos[2:0] - 3'd1]);
      end else if (wsp_pos == POSITION_BITS'(22)) begin
         wsp_ok = (b == odpnd_pkg::VERSION_HI);
      end else if (wsp_pos == POSITION_BITS'(23)) begin
         wsp_ok = (b[7:6] == odpnd_pkg::VERSION_LO) && (b[3:0] == odpnd_pkg::FLAG_NIBBLE);
      end else if (wsp_pos >= POSITION_BITS'(24) && wsp_pos <= POSITION_BITS'(26)) begin
         wsp_ok = (b == 8'h00);
      end else if (wsp_pos == ID_OFF) begin
         wsp_ok = (b != 8'h00);
      end else if (wsp_pos > ID_OFF) begin
         // Identifier bytes must be printable; anything past the identifier makes the payload overlong.
         wsp_ok = (wsp_pos < ID_FIRST + POSITION_BITS'(sid_len_ff))
                  && (b >= odpnd_pkg::PRINTABLE_MIN) && (b <= odpnd_pkg::PRINTABLE_MAX);
      end
   end

   assign byte_ok = in_wdp ? wdp_ok : wsp_ok;

   always_comb begin
      sid_len_in   = sid_len_ff;
      mismatch_in  = mismatch_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      verdict_in   = verdict_ff;
      if (consume) begin
         if (!in_wdp && wsp_pos == ID_OFF) begin
            sid_len_in = b;
         end
         mismatch_in = mismatch_ff || !byte_ok;
         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + POSITION_BITS'(1);
         end
         if (s1_last_ff) begin
            rsp_valid_in = 1'b1;
            verdict_in   = !mismatch_in && (sid_len_in != 8'h00)
                           && (pos_ff == base + ID_OFF + POSITION_BITS'(sid_len_in));
            pos_in       = '0;
            mismatch_in  = 1'b0;
            sid_len_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wdp_mode_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         pos_ff       <= '0;
         mismatch_ff  <= 1'b0;
         sid_len_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            wdp_mode_ff <= csr_write_data;
         end
         if (req_if.ready) begin
            s1_valid_ff <= req_if.valid;
         end
         pos_ff       <= pos_in;
         mismatch_ff  <= mismatch_in;
         sid_len_ff   <= sid_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         s1_byte_ff <= req_if.data_byte;
         s1_last_ff <= req_if.last_byte;
      end
      verdict_ff <= verdict_in;
   end

   // The message state is back at its reset values after a last byte.
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      consume && s1_last_ff |=> pos_ff == '0 && !mismatch_ff && sid_len_ff == '0)
      else $error("message state not cleared after last byte");

   // A byte that is not last moves the position on by one until saturation.
   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      consume && !s1_last_ff && pos_ff != POS_MAX |=> pos_ff == $past(pos_ff) + POSITION_BITS'(1))
      else $error("byte position did not advance");

   // Requests are refused only when the check stage is held by a waiting verdict.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> s1_valid_ff && rsp_valid_ff && !rsp_if.ready)
      else $error("request refused without a stalled response");

endmodule

`default_nettype wire
